// File: sv/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int IDX_W           = 4;
    localparam int MAX_BLOCKS      = 1 << IDX_W;
    localparam int ADDR_W          = 32;
    localparam int CNT_W           = 32;
    localparam int NUM_BLOCKS_DEF  = 16;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int PADDR_W         = 3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE     = 2'd2;
    localparam logic [1:0] ST_DOUBLE_FREE = 2'd3;

    localparam logic [PADDR_W-1:0] REG_POOL_BASE = 3'd0;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
    } in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [ADDR_W-1:0]     block_address;
        logic [IDX_W-1:0]      block_index;
        logic [CNT_W-1:0]      use_count;
        logic [CNT_W-1:0]      alloc_total;
        logic [CNT_W-1:0]      free_total;
        logic [MAX_BLOCKS-1:0] free_blocks;
    } out_t;

    // Decoded request: hit marks that the block fields describe a real block
    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] idx;
        logic             hit;
    } dec_t;

endpackage

// File: sv/bba_decode.sv
`timescale 1ns / 1ps

module bba_decode
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic                  operation,
    input  logic [ADDR_W-1:0]     address,
    input  logic [ADDR_W-1:0]     pool_base,
    input  logic [MAX_BLOCKS-1:0] free_map,
    output dec_t                  dec
);

    localparam logic [ADDR_W:0] SPAN = (ADDR_W+1)'(NUM_BLOCKS * BLOCK_BYTES);

    logic [ADDR_W:0]  offset;
    logic             outside;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] alloc_idx;
    logic             found;

    // Offset goes past 2^32 when the address lies below the pool base
    assign offset  = {1'b0, address} - {1'b0, pool_base};
    assign outside = (offset >= SPAN);

    // Block index of the offset: highest block start not above it
    always_comb
    begin
        free_idx = '0;
        for (int k = 1; k < MAX_BLOCKS; k++)
        begin
            if (k < NUM_BLOCKS && offset >= (ADDR_W+1)'(k * BLOCK_BYTES))
            begin
                free_idx = IDX_W'(k);
            end
        end
    end

    // Lowest free block wins
    always_comb
    begin
        alloc_idx = '0;
        found     = 1'b0;
        for (int k = MAX_BLOCKS - 1; k >= 0; k--)
        begin
            if (free_map[k])
            begin
                alloc_idx = IDX_W'(k);
                found     = 1'b1;
            end
        end
    end

    always_comb
    begin
        dec = '{status: ST_OK, idx: '0, hit: 1'b0};
        priority if (operation == OP_ALLOC)
        begin
            if (found)
            begin
                dec = '{status: ST_OK, idx: alloc_idx, hit: 1'b1};
            end
            else
            begin
                dec = '{status: ST_EXHAUSTED, idx: '0, hit: 1'b0};
            end
        end
        else if (outside)
        begin
            dec = '{status: ST_OUTSIDE, idx: '0, hit: 1'b0};
        end
        else if (free_map[free_idx])
        begin
            dec = '{status: ST_DOUBLE_FREE, idx: free_idx, hit: 1'b1};
        end
        else
        begin
            dec = '{status: ST_OK, idx: free_idx, hit: 1'b1};
        end
    end

endmodule

// File: sv/bba_use_mem.sv
`timescale 1ns / 1ps

module bba_use_mem
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] raddr,
    output logic [CNT_W-1:0] rdata,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [CNT_W-1:0] wdata
);

    logic [CNT_W-1:0]      mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [CNT_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;

    // Entry not yet written reads as zero
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

endmodule

// File: sv/bitmap_block_allocator.sv
`timescale 1ns / 1ps

// Fixed-size block pool allocator. An allocate transaction takes the lowest
// free block and returns its address; a free transaction returns a block by
// any byte address inside it. Each result carries a status (ok, pool
// exhausted, address outside pool, double free), the block's address, index
// and allocation count, both running totals and the free bitmap after the
// step; a failed request changes nothing. The pool starts at the pool_base
// register (byte address 0 on the APB port). A transaction is decoded, and
// the block's use count read from the count memory, as it is accepted; the
// update state then writes the count back and updates the bitmap and totals
// once the output register is free. The result sits there, and the next
// transaction is accepted the clock after the write-back even while it waits.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_t                in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_t               out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_UPDATE = 1'b1;

    localparam logic [MAX_BLOCKS-1:0] MAP_RESET =
        MAX_BLOCKS'(((MAX_BLOCKS+1)'(1) << NUM_BLOCKS) - (MAX_BLOCKS+1)'(1));

    logic                  state_reg, state_next;
    logic [ADDR_W-1:0]     pool_base_reg;
    logic [MAX_BLOCKS-1:0] free_map_reg, free_map_next;
    logic [CNT_W-1:0]      alloc_reg, alloc_next;
    logic [CNT_W-1:0]      release_reg, release_next;
    logic                  out_valid_reg, out_valid_next;
    out_t                  out_reg;
    logic                  op_reg;
    dec_t                  dec_reg;

    dec_t                  dec;
    logic                  accept;
    logic                  done;
    logic                  slot_free;
    logic                  alloc_ok;
    logic                  free_ok;
    logic [IDX_W-1:0]      raddr;
    logic [CNT_W-1:0]      uses_rd;
    logic [CNT_W-1:0]      uses_inc;
    out_t                  result;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_POOL_BASE) ? pool_base_reg : '0;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign done      = (state_reg == S_UPDATE) && slot_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    bba_decode #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_decode (
        .operation (in_data.operation),
        .address   (in_data.address),
        .pool_base (pool_base_reg),
        .free_map  (free_map_reg),
        .dec       (dec)
    );

    // Hold the read address while the result waits so the read data stays put
    assign raddr    = accept ? dec.idx : dec_reg.idx;
    assign alloc_ok = (op_reg == OP_ALLOC) && (dec_reg.status == ST_OK);
    assign free_ok  = (op_reg == OP_FREE) && (dec_reg.status == ST_OK);
    assign uses_inc = uses_rd + CNT_W'(1);

    bba_use_mem u_use_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (raddr),
        .rdata (uses_rd),
        .we    (done && alloc_ok),
        .waddr (dec_reg.idx),
        .wdata (uses_inc)
    );

    always_comb
    begin
        free_map_next = free_map_reg;
        alloc_next    = alloc_reg;
        release_next  = release_reg;
        if (alloc_ok)
        begin
            free_map_next[dec_reg.idx] = 1'b0;
            alloc_next                 = alloc_reg + CNT_W'(1);
        end
        if (free_ok)
        begin
            free_map_next[dec_reg.idx] = 1'b1;
            release_next               = release_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        result.status        = dec_reg.status;
        result.block_address = '0;
        result.block_index   = '0;
        result.use_count     = '0;
        result.alloc_total   = alloc_next;
        result.free_total    = release_next;
        result.free_blocks   = free_map_next;
        if (dec_reg.hit)
        begin
            result.block_address = pool_base_reg
                + ADDR_W'(ADDR_W'(dec_reg.idx) * ADDR_W'(BLOCK_BYTES));
            result.block_index   = dec_reg.idx;
            result.use_count     = alloc_ok ? uses_inc : uses_rd;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (done)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pool_base_reg <= '0;
            free_map_reg  <= MAP_RESET;
            alloc_reg     <= '0;
            release_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && paddr == REG_POOL_BASE)
            begin
                pool_base_reg <= pwdata;
            end
            if (done)
            begin
                free_map_reg <= free_map_next;
                alloc_reg    <= alloc_next;
                release_reg  <= release_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_data.operation;
            dec_reg <= dec;
        end
        if (done)
        begin
            out_reg <= result;
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import bba_pkg::*;

    localparam int NBLK         = NUM_BLOCKS_DEF;
    localparam int BLK_BYTES    = BLOCK_BYTES_DEF;
    localparam int POOL_BYTES   = NBLK * BLK_BYTES;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTED  = 100;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_t                in_data;
    logic               out_valid;
    logic               out_stall;
    out_t               out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Allocator state as the testbench expects it
    logic [31:0]           pool_base_cfg;
    logic [MAX_BLOCKS-1:0] free_map_m;
    logic [CNT_W-1:0]      use_hist [MAX_BLOCKS];
    logic [CNT_W-1:0]      alloc_cnt;
    logic [CNT_W-1:0]      release_cnt;
    out_t                  pending_results [$];

    int err_count   = 0;
    int result_no   = 0;
    int cycle_count = 0;
    int sink_wait   = 0;
    bit no_idle     = 1'b0;

    bitmap_block_allocator #(
        .NUM_BLOCKS  (NBLK),
        .BLOCK_BYTES (BLK_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is %h, expected %h",
                                   result_no, name, got, want));
    endtask

    function automatic void reset_model();
        int i;
        pool_base_cfg = '0;
        free_map_m    = MAX_BLOCKS'((64'd1 << NBLK) - 1);
        for (i = 0; i < MAX_BLOCKS; i++)
            use_hist[i] = '0;
        alloc_cnt   = '0;
        release_cnt = '0;
    endfunction

    // Work out the result of one request and advance the expected state
    function automatic out_t apply_request(input in_t req);
        out_t             r;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [63:0]      a;
        logic [IDX_W-1:0] idx;
        bit               found;
        int               i;
        r = '0;
        if (req.operation == OP_ALLOC)
        begin
            if (free_map_m == '0)
                r.status = ST_EXHAUSTED;
            else
            begin
                found = 1'b0;
                idx   = '0;
                for (i = 0; i < NBLK; i++)
                    if (!found && free_map_m[i])
                    begin
                        idx   = i[IDX_W-1:0];
                        found = 1'b1;
                    end
                free_map_m[idx] = 1'b0;
                use_hist[idx]   = use_hist[idx] + 1;
                alloc_cnt       = alloc_cnt + 1;
                r.status        = ST_OK;
                r.block_address = pool_base_cfg + 32'(idx) * 32'(BLK_BYTES);
                r.block_index   = idx;
                r.use_count     = use_hist[idx];
            end
        end
        else
        begin
            lo = {32'd0, pool_base_cfg};
            hi = lo + 64'(POOL_BYTES);
            a  = {32'd0, req.address};
            if (a < lo || a >= hi)
                r.status = ST_OUTSIDE;
            else
            begin
                idx             = IDX_W'((a - lo) / BLK_BYTES);
                r.block_address = pool_base_cfg + 32'(idx) * 32'(BLK_BYTES);
                r.block_index   = idx;
                r.use_count     = use_hist[idx];
                if (free_map_m[idx])
                    r.status = ST_DOUBLE_FREE;
                else
                begin
                    free_map_m[idx] = 1'b1;
                    release_cnt     = release_cnt + 1;
                    r.status        = ST_OK;
                end
            end
        end
        r.alloc_total = alloc_cnt;
        r.free_total  = release_cnt;
        r.free_blocks = free_map_m;
        return r;
    endfunction

    // Random block that is currently free (want_free) or held; -1 if none
    function automatic int pick_block(input bit want_free);
        int candidates [$];
        int i;
        for (i = 0; i < NBLK; i++)
            if (free_map_m[i] == want_free)
                candidates.push_back(i);
        if (candidates.size() == 0)
            return -1;
        return candidates[$urandom_range(0, candidates.size() - 1)];
    endfunction

    function automatic logic [31:0] byte_in_block(input int blk);
        return pool_base_cfg + 32'(blk * BLK_BYTES) + 32'($urandom_range(0, BLK_BYTES - 1));
    endfunction

    // Mostly allocs and frees of held blocks, the rest double frees, random and pool-edge addresses
    function automatic in_t make_request();
        in_t req;
        int  pick;
        int  blk;
        req.operation = OP_ALLOC;
        req.address   = $urandom();
        pick          = $urandom_range(0, 99);
        if (pick >= 45)
        begin
            req.operation = OP_FREE;
            if (pick < 80)
            begin
                blk = pick_block(1'b0);
                if (blk < 0)
                    req.operation = OP_ALLOC;
                else
                    req.address = byte_in_block(blk);
            end
            else if (pick < 87)
            begin
                blk = pick_block(1'b1);
                if (blk < 0)
                    blk = $urandom_range(0, NBLK - 1);
                req.address = byte_in_block(blk);
            end
            else if (pick >= 93)
            begin
                case ($urandom_range(0, 3))
                    0: req.address = pool_base_cfg - 1;
                    1: req.address = pool_base_cfg;
                    2: req.address = pool_base_cfg + POOL_BYTES - 1;
                    default: req.address = pool_base_cfg + POOL_BYTES;
                endcase
            end
        end
        return req;
    endfunction

    task automatic send_item(input in_t req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_request(req));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write pool_base, then read it back
    task automatic set_pool_base(input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_POOL_BASE;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pool_base_cfg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
            report_error($sformatf("pool_base reads %h, expected %h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_exhaust_pool();
        in_t req;
        int  i;
        set_pool_base(32'h0000_0000);
        for (i = 0; i <= NBLK; i++)
        begin
            req.operation = OP_ALLOC;
            req.address   = $urandom();
            send_item(req);
        end
    endtask

    task automatic test_release_paths();
        in_t         req;
        logic [31:0] low_pool [6]  = '{32'h0000_0000, 32'h0000_0165, 32'h0000_03FF,
                                       32'h0000_0400, 32'hFFFF_FFFF, 32'h0000_0020};
        logic [31:0] high_pool [3] = '{32'h0000_0FFF, 32'h0000_10BF, 32'h0000_13FF};
        int          i;
        req.operation = OP_FREE;
        // block start, mid-block, last pool byte, one past, top of space, double free
        for (i = 0; i < 6; i++)
        begin
            req.address = low_pool[i];
            send_item(req);
        end
        set_pool_base(32'h0000_1000);
        // just below the pool, last byte of a held block, double free at the top
        for (i = 0; i < 3; i++)
        begin
            req.address = high_pool[i];
            send_item(req);
        end
        req.operation = OP_ALLOC;
        req.address   = 32'h0000_0000;
        send_item(req);
    endtask

    task automatic test_random_traffic(input int count, input logic [31:0] base,
                                       input bit burst);
        set_pool_base(base);
        no_idle = burst;
        repeat (count) send_item(make_request());
        no_idle = 1'b0;
    endtask

    // Sink side: wait a random number of cycles after each transaction
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sink_wait = no_idle ? 0 : $urandom_range(0, 6);
        else if (sink_wait > 0)
            sink_wait--;
        out_stall <= (sink_wait > 0);
    end

    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("result %0d arrived with nothing pending", result_no));
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(out_data.status), 32'(want.status));
                check_field("block_address", out_data.block_address, want.block_address);
                check_field("block_index", 32'(out_data.block_index), 32'(want.block_index));
                check_field("use_count", out_data.use_count, want.use_count);
                check_field("alloc_total", out_data.alloc_total, want.alloc_total);
                check_field("free_total", out_data.free_total, want.free_total);
                check_field("free_blocks", 32'(out_data.free_blocks), 32'(want.free_blocks));
            end
            result_no++;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_exhaust_pool();
        test_release_paths();
        test_random_traffic(300, $urandom(), 1'b0);
        // pool runs past the top of the address space
        test_random_traffic(120, 32'hFFFF_FF00, 1'b0);
        test_random_traffic(80, 32'hFFFF_FFFF, 1'b0);
        test_random_traffic(250, $urandom(), 1'b1);
        test_random_traffic(200, 32'h0000_0000, 1'b0);
        test_random_traffic(200, $urandom(), 1'b0);
        wait_idle();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
